@@ design/tsm_pkg.sv @@
// Shared types, constants and codes for the tone sequence matcher.
// Used by tsm_ctrl, tsm_datapath and tone_sequence_matcher_unit; no dependencies.
`default_nettype none

package tsm_pkg;

   // sizes fixed by the widths of the word fields
   localparam int FRAME_WINDOW_DEF  = 32;
   localparam int HISTORY_DEPTH_DEF = 64;
   localparam int MAX_SEQ   = 8;
   localparam int MAX_SMP   = 4;
   localparam int MAX_PFR   = 32;
   localparam int FREQS     = 4;
   localparam int SEQ_W     = 3;
   localparam int SMP_W     = 2;
   localparam int PFR_W     = 5;
   localparam int FREQ_W    = 16;
   localparam int DEV_W     = 8;
   localparam int LEN_W     = 6;
   localparam int CNT_W     = 3;
   localparam int OP_W      = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;
   // wide enough for any window or history position plus a sample length
   localparam int CMP_W     = 9;

   localparam logic [DEV_W-1:0] DEV_NONE = 8'hFF;

   // word opcodes
   localparam logic [OP_W-1:0] OP_FRAME  = 3'd0;
   localparam logic [OP_W-1:0] OP_PFREQ  = 3'd1;
   localparam logic [OP_W-1:0] OP_SLEN   = 3'd2;
   localparam logic [OP_W-1:0] OP_SEQCFG = 3'd3;
   localparam logic [OP_W-1:0] OP_ALLOW  = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DEV   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALL_FREQ  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_COUNT = 2'd2;

   typedef struct packed {
      logic             accept;
      logic             best_init;
      logic             dev_zero;
      logic             hist_rd;
      logic             hist_alt;
      logic             h1_eval;
      logic             h2_eval;
      logic             pat_start;
      logic             pat_rd;
      logic             pat_eval;
      logic             smp_done;
      logic             hist_wr;
      logic             finish;
      logic             rsp_load;
      logic [SEQ_W-1:0] seq;
      logic [SMP_W:0]   smp;
      logic [PFR_W-1:0] idx;
      logic [PFR_W-1:0] rd_idx;
   } tsm_cmd_type;

   typedef struct packed {
      logic smp_end;
      logic len_short;
      logic len_zero;
      logic hist_none;
      logic dev_reject;
      logic pat_last;
      logic pat_break;
      logic seq_last;
   } tsm_status_type;

endpackage

`default_nettype wire

@@ design/tone_sequence_matcher_unit.sv @@
// rsp_valid rises after a load, clear or spare-opcode word is accepted, once S_DONE has
// loaded the output register. A frame word is scored by the controller walking sequences
// and samples, and one pattern frame per cycle through the pattern and window memories.
// One word at a time: req_ready returns in the cycle after the result is loaded, and a
// result not yet taken holds the load. Reset (synchronous, active high) empties the
// frame window and the score history. Joins tsm_ctrl and tsm_datapath.
`default_nettype none

module tone_sequence_matcher_unit import tsm_pkg::*; #(
   parameter int FRAME_WINDOW  = FRAME_WINDOW_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [OP_W-1:0]      req_opcode,
   input  wire logic [CNT_W-1:0]     req_freq_count,
   input  wire logic [FREQ_W-1:0]    req_freq_0,
   input  wire logic [FREQ_W-1:0]    req_freq_1,
   input  wire logic [FREQ_W-1:0]    req_freq_2,
   input  wire logic [FREQ_W-1:0]    req_freq_3,
   input  wire logic [SEQ_W-1:0]     req_seq_index,
   input  wire logic [SMP_W-1:0]     req_sample_index,
   input  wire logic [PFR_W-1:0]     req_frame_index,
   input  wire logic [FREQ_W-1:0]    req_load_value,
   input  wire logic [DEV_W-1:0]     req_load_count,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_matched,
   output logic [DEV_W-1:0]          rsp_final_deviation,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);

   tsm_cmd_type    cmd;
   tsm_status_type status;

   tsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   tsm_datapath #(
      .FRAME_WINDOW  (FRAME_WINDOW),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_opcode          (req_opcode),
      .req_freq_count      (req_freq_count),
      .req_freq_0          (req_freq_0),
      .req_freq_1          (req_freq_1),
      .req_freq_2          (req_freq_2),
      .req_freq_3          (req_freq_3),
      .req_seq_index       (req_seq_index),
      .req_sample_index    (req_sample_index),
      .req_frame_index     (req_frame_index),
      .req_load_value      (req_load_value),
      .req_load_count      (req_load_count),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_matched         (rsp_matched),
      .rsp_final_deviation (rsp_final_deviation)
   );

endmodule

`default_nettype wire

@@ design/tsm_datapath.sv @@
// Datapath: registers, pattern/frame/history memories and scoring arithmetic.
// Depends on tsm_pkg; driven by tsm_ctrl through tsm_cmd_type.
`default_nettype none

module tsm_datapath import tsm_pkg::*; #(
   parameter int FRAME_WINDOW  = FRAME_WINDOW_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tsm_cmd_type          cmd,
   output tsm_status_type            status,
   input  wire logic [OP_W-1:0]      req_opcode,
   input  wire logic [CNT_W-1:0]     req_freq_count,
   input  wire logic [FREQ_W-1:0]    req_freq_0,
   input  wire logic [FREQ_W-1:0]    req_freq_1,
   input  wire logic [FREQ_W-1:0]    req_freq_2,
   input  wire logic [FREQ_W-1:0]    req_freq_3,
   input  wire logic [SEQ_W-1:0]     req_seq_index,
   input  wire logic [SMP_W-1:0]     req_sample_index,
   input  wire logic [PFR_W-1:0]     req_frame_index,
   input  wire logic [FREQ_W-1:0]    req_load_value,
   input  wire logic [DEV_W-1:0]     req_load_count,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data,
   output logic                      rsp_matched,
   output logic [DEV_W-1:0]          rsp_final_deviation
);

   localparam int FA_W    = $clog2(FRAME_WINDOW);
   localparam int FH_W    = $clog2(FRAME_WINDOW + 1);
   localparam int HA_W    = $clog2(HISTORY_DEPTH);
   localparam int HH_W    = $clog2(HISTORY_DEPTH + 1);
   localparam int F_HALF  = FRAME_WINDOW / 2;
   localparam int F_SHIFT = FRAME_WINDOW - F_HALF;
   localparam int H_HALF  = HISTORY_DEPTH / 2;
   localparam int H_SHIFT = HISTORY_DEPTH - H_HALF;
   localparam int FRAME_W = CNT_W + FREQS * FREQ_W;

   // configuration registers
   logic [DEV_W-1:0] max_dev_ff;
   logic             all_freq_ff;
   logic [3:0]       seq_count_ff;

   // small tables
   logic [LEN_W-1:0]  slen_ff   [MAX_SEQ*MAX_SMP];
   logic [CNT_W-1:0]  nsamp_ff  [MAX_SEQ];
   logic [FREQ_W-1:0] thr_ff    [MAX_SEQ];
   logic [DEV_W-1:0]  allow_ff  [MAX_SEQ];

   // memories
   logic [FRAME_W-1:0] frame_mem [FRAME_WINDOW];
   logic [FREQ_W-1:0]  pat_mem   [MAX_SEQ*MAX_SMP*MAX_PFR];
   logic [DEV_W-1:0]   hist_mem  [HISTORY_DEPTH*MAX_SEQ];
   logic [FRAME_W-1:0] frame_rd_ff;
   logic [FREQ_W-1:0]  pat_rd_ff;
   logic [DEV_W-1:0]   hist_rd_ff;

   // window and history bookkeeping
   logic [FH_W-1:0] fheld_ff, fheld_in;
   logic [FA_W-1:0] fbase_ff, fbase_in;
   logic [HH_W-1:0] hheld_ff, hheld_in;
   logic [HA_W-1:0] hbase_ff, hbase_in;

   // scoring registers
   logic [DEV_W-1:0] dev_ff, dev_in;
   logic [DEV_W-1:0] best_ff, best_in;
   logic [DEV_W-1:0] left_ff, left_in;
   logic             res_matched_ff;
   logic [DEV_W-1:0] res_final_ff;

   function automatic logic [FA_W-1:0] frame_wrap(input logic [CMP_W-1:0] v);
      if (v >= CMP_W'(FRAME_WINDOW)) begin
         frame_wrap = FA_W'(v - CMP_W'(FRAME_WINDOW));
      end else begin
         frame_wrap = FA_W'(v);
      end
   endfunction

   function automatic logic [HA_W-1:0] hist_wrap(input logic [CMP_W-1:0] v);
      if (v >= CMP_W'(HISTORY_DEPTH)) begin
         hist_wrap = HA_W'(v - CMP_W'(HISTORY_DEPTH));
      end else begin
         hist_wrap = HA_W'(v);
      end
   endfunction

   // current sample's parameters
   logic [LEN_W-1:0]  cur_len;
   logic [CMP_W-1:0]  len_w, len1_w, back_w, fheld_w, hheld_w;
   logic [SEQ_W-1:0]  seq_last_idx;
   logic              short_len, short_len1, hist_short;
   logic [HA_W-1:0]   hrow_rd, hrow_wr;
   logic [FA_W-1:0]   frame_wr_addr, frame_rd_addr;
   logic [CNT_W-1:0]  cnt_clamped;
   logic [DEV_W-1:0]  h1_val, h2_val;

   assign cur_len    = slen_ff[{cmd.seq, cmd.smp[SMP_W-1:0]}];
   assign len_w      = CMP_W'(cur_len);
   assign len1_w     = len_w + CMP_W'(1);
   assign fheld_w    = CMP_W'(fheld_ff);
   assign hheld_w    = CMP_W'(hheld_ff);
   assign short_len  = hheld_w < len_w;
   assign short_len1 = hheld_w < len1_w;
   assign back_w     = cmd.hist_alt ? len1_w : len_w;
   assign hist_short = hheld_w < back_w;
   assign hrow_rd    = hist_short ? '0
                       : hist_wrap(CMP_W'(hbase_ff) + (hheld_w - back_w));
   assign hrow_wr    = hist_wrap(CMP_W'(hbase_ff) + hheld_w);
   assign frame_wr_addr = frame_wrap(CMP_W'(fbase_ff) + fheld_w);
   assign frame_rd_addr = frame_wrap(CMP_W'(fbase_ff) + (fheld_w - len_w)
                                     + CMP_W'(cmd.rd_idx));
   assign cnt_clamped = (req_freq_count > CNT_W'(FREQS)) ? CNT_W'(FREQS) : req_freq_count;
   assign h1_val      = short_len ? DEV_NONE : hist_rd_ff;
   assign h2_val      = short_len1 ? DEV_NONE : hist_rd_ff;

   always_comb begin
      if (seq_count_ff == 4'd0) begin
         seq_last_idx = '0;
      end else if (seq_count_ff > 4'(MAX_SEQ)) begin
         seq_last_idx = SEQ_W'(MAX_SEQ - 1);
      end else begin
         seq_last_idx = SEQ_W'(seq_count_ff - 4'd1);
      end
   end

   // compare one pattern frame against the window frame
   logic [FREQ_W-1:0] want, thr, diff;
   logic [CNT_W-1:0]  fcnt;
   logic [FREQ_W-1:0] dist_arr [FREQS];
   logic              miss, brk;
   logic [DEV_W-1:0]  pat_dev, pat_left;

   always_comb begin
      want = pat_rd_ff;
      fcnt = frame_rd_ff[FRAME_W-1 -: CNT_W];
      thr  = thr_ff[cmd.seq];
      for (int j = 0; j < FREQS; j++) begin
         logic [FREQ_W-1:0] f;
         f = frame_rd_ff[j*FREQ_W +: FREQ_W];
         dist_arr[j] = (want > f) ? (want - f) : (f - want);
      end
      diff = dist_arr[0];
      for (int j = 1; j < FREQS; j++) begin
         if (all_freq_ff && (CNT_W'(j) < fcnt) && (dist_arr[j] < diff)) begin
            diff = dist_arr[j];
         end
      end
      miss     = diff > thr;
      brk      = 1'b0;
      pat_dev  = dev_ff;
      pat_left = left_ff;
      if (want == '0) begin
         pat_dev = dev_ff;
      end else if (fcnt == '0) begin
         if (dev_ff != DEV_NONE) begin
            pat_dev = dev_ff + DEV_W'(1);
         end
      end else if ((left_ff != '0) && miss && (dev_ff < max_dev_ff)) begin
         pat_left = left_ff - DEV_W'(1);
         pat_dev  = dev_ff + DEV_W'(1);
      end else if (miss) begin
         pat_dev = DEV_NONE;
         brk     = 1'b1;
      end
   end

   // status back to the controller
   always_comb begin
      status.smp_end    = cmd.smp >= nsamp_ff[cmd.seq];
      status.len_short  = fheld_w < len_w;
      status.len_zero   = cur_len == '0;
      status.hist_none  = h1_val == DEV_NONE;
      status.dev_reject = (dev_ff > max_dev_ff) || (dev_ff >= best_ff);
      status.pat_last   = (CMP_W'(cmd.idx) + CMP_W'(1)) == len_w;
      status.pat_break  = brk;
      status.seq_last   = cmd.seq == seq_last_idx;
   end

   // score registers next values
   always_comb begin
      dev_in  = dev_ff;
      best_in = best_ff;
      left_in = left_ff;
      if (cmd.best_init) begin
         best_in = DEV_NONE;
      end
      if (cmd.dev_zero) begin
         dev_in = '0;
      end
      if (cmd.h1_eval) begin
         dev_in = h1_val;
      end
      if (cmd.h2_eval) begin
         dev_in = h2_val;
      end
      if (cmd.pat_start) begin
         left_in = allow_ff[cmd.seq];
      end
      if (cmd.pat_eval) begin
         dev_in  = pat_dev;
         left_in = pat_left;
      end
      if (cmd.smp_done && (dev_ff < best_ff) && (dev_ff <= max_dev_ff)) begin
         best_in = dev_ff;
      end
   end

   always_ff @(posedge clock) begin
      dev_ff  <= dev_in;
      best_ff <= best_in;
      left_ff <= left_in;
   end

   // window and history counters
   always_comb begin
      fheld_in = fheld_ff;
      fbase_in = fbase_ff;
      hheld_in = hheld_ff;
      hbase_in = hbase_ff;
      if (cmd.accept && (req_opcode == OP_FRAME)) begin
         if ((fheld_w + CMP_W'(1)) >= CMP_W'(FRAME_WINDOW)) begin
            fheld_in = FH_W'(F_HALF);
            fbase_in = frame_wrap(CMP_W'(fbase_ff) + CMP_W'(F_SHIFT));
         end else begin
            fheld_in = fheld_ff + FH_W'(1);
         end
      end
      if (cmd.accept && (req_opcode == OP_CLEAR)) begin
         fheld_in = '0;
         hheld_in = '0;
      end
      if (cmd.finish) begin
         if ((hheld_w + CMP_W'(1)) >= CMP_W'(HISTORY_DEPTH)) begin
            hheld_in = HH_W'(H_HALF);
            hbase_in = hist_wrap(CMP_W'(hbase_ff) + CMP_W'(H_SHIFT));
         end else begin
            hheld_in = hheld_ff + HH_W'(1);
         end
         if (best_ff <= max_dev_ff) begin
            hheld_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fheld_ff <= '0;
         fbase_ff <= '0;
         hheld_ff <= '0;
         hbase_ff <= '0;
      end else begin
         fheld_ff <= fheld_in;
         fbase_ff <= fbase_in;
         hheld_ff <= hheld_in;
         hbase_ff <= hbase_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dev_ff   <= 8'd2;
         all_freq_ff  <= 1'b0;
         seq_count_ff <= 4'd1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MAX_DEV:   max_dev_ff   <= csr_data;
            CSR_ALL_FREQ:  all_freq_ff  <= csr_data[0];
            CSR_SEQ_COUNT: seq_count_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // load words into the tables
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         case (req_opcode)
            OP_SLEN: begin
               slen_ff[{req_seq_index, req_sample_index}] <=
                  (req_load_count > DEV_W'(MAX_PFR)) ? LEN_W'(MAX_PFR)
                                                      : LEN_W'(req_load_count);
            end
            OP_SEQCFG: begin
               thr_ff[req_seq_index]   <= req_load_value;
               nsamp_ff[req_seq_index] <=
                  (req_load_count > DEV_W'(MAX_SMP)) ? CNT_W'(MAX_SMP)
                                                      : CNT_W'(req_load_count);
            end
            OP_ALLOW: allow_ff[req_seq_index] <= req_load_count;
            default: ;
         endcase
      end
   end

   // pattern memory
   always_ff @(posedge clock) begin
      if (cmd.accept && (req_opcode == OP_PFREQ)) begin
         pat_mem[{req_seq_index, req_sample_index, req_frame_index}] <= req_load_value;
      end
      if (cmd.pat_rd) begin
         pat_rd_ff <= pat_mem[{cmd.seq, cmd.smp[SMP_W-1:0], cmd.rd_idx}];
      end
   end

   // frame window memory
   always_ff @(posedge clock) begin
      if (cmd.accept && (req_opcode == OP_FRAME)) begin
         frame_mem[frame_wr_addr] <= {cnt_clamped, req_freq_3, req_freq_2,
                                      req_freq_1, req_freq_0};
      end
      if (cmd.pat_rd) begin
         frame_rd_ff <= frame_mem[frame_rd_addr];
      end
   end

   // score history memory
   always_ff @(posedge clock) begin
      if (cmd.hist_wr) begin
         hist_mem[{hrow_wr, cmd.seq}] <= best_ff;
      end
      if (cmd.hist_rd) begin
         hist_rd_ff <= hist_mem[{hrow_rd, cmd.seq - SEQ_W'(1)}];
      end
   end

   // result of the current word and the output register
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res_matched_ff <= 1'b0;
         res_final_ff   <= DEV_NONE;
      end else if (cmd.finish) begin
         res_matched_ff <= best_ff <= max_dev_ff;
         res_final_ff   <= best_ff;
      end
      if (cmd.rsp_load) begin
         rsp_matched         <= res_matched_ff;
         rsp_final_deviation <= res_final_ff;
      end
   end

   // window and history positions stay inside their stores
   a_fheld_range: assert property (@(posedge clock) disable iff (reset)
      fheld_ff < FH_W'(FRAME_WINDOW))
      else $error("frame count reached the window size");
   a_hheld_range: assert property (@(posedge clock) disable iff (reset)
      hheld_ff < HH_W'(HISTORY_DEPTH))
      else $error("history count reached the history depth");
   a_pat_in_len: assert property (@(posedge clock) disable iff (reset)
      cmd.pat_eval |-> (CMP_W'(cmd.idx) < len_w))
      else $error("pattern frame evaluated beyond sample length");

endmodule

`default_nettype wire

@@ design/tsm_ctrl.sv @@
// Controller: walks sequences, samples and pattern frames for each frame word.
// Depends on tsm_pkg; commands tsm_datapath and owns the result valid flag.
`default_nettype none

module tsm_ctrl import tsm_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [OP_W-1:0] req_opcode,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output tsm_cmd_type          cmd,
   input  wire tsm_status_type  status
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SEQ     = 4'd1;
   localparam logic [3:0] S_SMP     = 4'd2;
   localparam logic [3:0] S_H1      = 4'd3;
   localparam logic [3:0] S_H2      = 4'd4;
   localparam logic [3:0] S_CHK     = 4'd5;
   localparam logic [3:0] S_PAT     = 4'd6;
   localparam logic [3:0] S_SMPEND  = 4'd7;
   localparam logic [3:0] S_SEQEND  = 4'd8;
   localparam logic [3:0] S_FIN     = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   logic [3:0]       state_ff, state_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [SMP_W:0]   smp_ff, smp_in;
   logic [PFR_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      seq_in     = seq_ff;
      smp_in     = smp_ff;
      idx_in     = idx_ff;
      cmd        = '0;
      cmd.seq    = seq_ff;
      cmd.smp    = smp_ff;
      cmd.idx    = idx_ff;
      cmd.rd_idx = idx_ff + PFR_W'(1);
      case (state_ff)
         S_IDLE: begin
            cmd.accept = accept;
            seq_in     = '0;
            if (accept) begin
               state_in = (req_opcode == OP_FRAME) ? S_SEQ : S_DONE;
            end
         end
         S_SEQ: begin
            cmd.best_init = 1'b1;
            smp_in        = '0;
            state_in      = S_SMP;
         end
         S_SMP: begin
            if (status.smp_end) begin
               state_in = S_SEQEND;
            end else if (status.len_short) begin
               smp_in = smp_ff + 3'd1;
            end else if (seq_ff == '0) begin
               cmd.dev_zero = 1'b1;
               state_in     = S_CHK;
            end else begin
               cmd.hist_rd = 1'b1;
               state_in    = S_H1;
            end
         end
         S_H1: begin
            cmd.h1_eval = 1'b1;
            if (status.hist_none) begin
               cmd.hist_rd  = 1'b1;
               cmd.hist_alt = 1'b1;
               state_in     = S_H2;
            end else begin
               state_in = S_CHK;
            end
         end
         S_H2: begin
            cmd.h2_eval = 1'b1;
            state_in    = S_CHK;
         end
         S_CHK: begin
            if (status.dev_reject) begin
               smp_in   = smp_ff + 3'd1;
               state_in = S_SMP;
            end else begin
               cmd.pat_start = 1'b1;
               if (status.len_zero) begin
                  state_in = S_SMPEND;
               end else begin
                  cmd.pat_rd = 1'b1;
                  cmd.rd_idx = '0;
                  idx_in     = '0;
                  state_in   = S_PAT;
               end
            end
         end
         S_PAT: begin
            cmd.pat_eval = 1'b1;
            if (status.pat_break || status.pat_last) begin
               state_in = S_SMPEND;
            end else begin
               cmd.pat_rd = 1'b1;
               idx_in     = idx_ff + PFR_W'(1);
            end
         end
         S_SMPEND: begin
            cmd.smp_done = 1'b1;
            smp_in       = smp_ff + 3'd1;
            state_in     = S_SMP;
         end
         S_SEQEND: begin
            cmd.hist_wr = 1'b1;
            if (status.seq_last) begin
               state_in = S_FIN;
            end else begin
               seq_in   = seq_ff + SEQ_W'(1);
               state_in = S_SEQ;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold the result word until taken
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seq_ff       <= '0;
         smp_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         smp_ff       <= smp_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_frame_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == OP_FRAME)) |=> (state_ff == S_SEQ && seq_ff == '0))
      else $error("frame word did not start at the first sequence");
   a_done_hands_off: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) |=>
      (state_ff == S_IDLE && rsp_valid_ff))
      else $error("finished word not handed to the output register");
   a_fin_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> $past(state_ff == S_SEQEND && status.seq_last))
      else $error("finish reached without scoring the last sequence");

endmodule

`default_nettype wire

@@ tb/tb_tone_sequence_matcher_unit.sv @@
// Self-checking testbench for tone_sequence_matcher_unit: programs pattern tables,
// streams frames with random idling and checks every result word against a predictor.
// Depends on tsm_pkg and the design sources.
`timescale 1ns / 100ps

module tb_tone_sequence_matcher_unit;
   import tsm_pkg::*;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [CNT_W-1:0]  fcnt;
      logic [FREQ_W-1:0] f [FREQS];
      logic [SEQ_W-1:0]  seq;
      logic [SMP_W-1:0]  smp;
      logic [PFR_W-1:0]  fidx;
      logic [FREQ_W-1:0] lval;
      logic [DEV_W-1:0]  lcnt;
   } word_type;

   typedef struct {
      logic             matched;
      logic [DEV_W-1:0] dev;
   } verdict_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [OP_W-1:0]      req_opcode;
   logic [CNT_W-1:0]     req_freq_count;
   logic [FREQ_W-1:0]    req_freq_0, req_freq_1, req_freq_2, req_freq_3;
   logic [SEQ_W-1:0]     req_seq_index;
   logic [SMP_W-1:0]     req_sample_index;
   logic [PFR_W-1:0]     req_frame_index;
   logic [FREQ_W-1:0]    req_load_value;
   logic [DEV_W-1:0]     req_load_count;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_matched;
   logic [DEV_W-1:0]     rsp_final_deviation;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   tone_sequence_matcher_unit dut (.*);

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   word_type    pending_words[$];
   verdict_type expected_verdicts[$];
   int          mismatches = 0;

   // ---------------- predictor state ----------------
   int       p_max_dev, p_all_freq, p_seq_count;
   int       p_fsize [FRAME_WINDOW_DEF];
   int       p_ffreq [FRAME_WINDOW_DEF*FREQS];
   int       p_frames;
   int       p_pat [MAX_SEQ*MAX_SMP*MAX_PFR];
   int       p_slen [MAX_SEQ*MAX_SMP];
   int       p_nsmp [MAX_SEQ];
   int       p_thr [MAX_SEQ];
   int       p_allow [MAX_SEQ];
   int       p_hist [HISTORY_DEPTH_DEF*MAX_SEQ];
   int       p_rows;

   function automatic int live_sequences();
      int n;
      n = p_seq_count & 15;
      if (n == 0) n = 1;
      if (n > MAX_SEQ) n = MAX_SEQ;
      return n;
   endfunction

   function automatic int earlier_score(int back, int seq);
      if (p_rows < back) return 255;
      return p_hist[(p_rows - back)*MAX_SEQ + seq];
   endfunction

   function automatic int tone_gap(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // best deviation of one sequence over its alternative samples
   function automatic int sequence_deviation(int seq);
      int best, len, dev, left, fr, want, cnt, diff, d;
      best = 255;
      for (int s = 0; s < p_nsmp[seq]; s++) begin
         len = p_slen[seq*MAX_SMP + s];
         if (p_frames < len) continue;
         if (seq == 0) dev = 0;
         else begin
            dev = earlier_score(len, seq - 1);
            if (dev == 255) dev = earlier_score(len + 1, seq - 1);
         end
         if (dev > p_max_dev || dev >= best) continue;
         left = p_allow[seq];
         for (int i = 0; i < len; i++) begin
            fr   = p_frames - len + i;
            want = p_pat[(seq*MAX_SMP + s)*MAX_PFR + i];
            cnt  = p_fsize[fr];
            if (want == 0) continue;
            if (cnt == 0) begin
               if (dev < 255) dev++;
               continue;
            end
            diff = tone_gap(want, p_ffreq[fr*FREQS]);
            if (p_all_freq != 0)
               for (int j = 1; j < cnt; j++) begin
                  d = tone_gap(want, p_ffreq[fr*FREQS + j]);
                  if (d < diff) diff = d;
               end
            if (left != 0 && diff > p_thr[seq] && dev < p_max_dev) begin
               left--;
               dev++;
            end else if (diff > p_thr[seq]) begin
               dev = 255;
               break;
            end
         end
         if (dev < best && dev <= p_max_dev) best = dev;
      end
      return best;
   endfunction

   // advance the predictor by one accepted word
   function automatic verdict_type predict_verdict(word_type w);
      verdict_type v;
      int cnt, n, sc;
      v.matched = 1'b0;
      v.dev     = DEV_NONE;
      case (w.op)
         OP_FRAME: begin
            cnt = (int'(w.fcnt) > FREQS) ? FREQS : int'(w.fcnt);
            p_fsize[p_frames] = cnt;
            for (int j = 0; j < FREQS; j++) p_ffreq[p_frames*FREQS + j] = int'(w.f[j]);
            p_frames++;
            if (p_frames >= FRAME_WINDOW_DEF) begin
               for (int k = 0; k < FRAME_WINDOW_DEF/2; k++) begin
                  p_fsize[k] = p_fsize[k + FRAME_WINDOW_DEF/2];
                  for (int j = 0; j < FREQS; j++)
                     p_ffreq[k*FREQS + j] = p_ffreq[(k + FRAME_WINDOW_DEF/2)*FREQS + j];
               end
               p_frames = FRAME_WINDOW_DEF/2;
            end
            n = live_sequences();
            for (int j = 0; j < n; j++) begin
               sc = sequence_deviation(j);
               p_hist[p_rows*MAX_SEQ + j] = sc;
            end
            p_rows++;
            if (p_rows >= HISTORY_DEPTH_DEF) begin
               for (int k = 0; k < (HISTORY_DEPTH_DEF/2)*MAX_SEQ; k++)
                  p_hist[k] = p_hist[k + (HISTORY_DEPTH_DEF/2)*MAX_SEQ];
               p_rows = HISTORY_DEPTH_DEF/2;
            end
            sc    = earlier_score(1, n - 1);
            v.dev = sc[DEV_W-1:0];
            if (sc <= p_max_dev) begin
               v.matched = 1'b1;
               p_rows    = 0;
            end
         end
         OP_PFREQ:  p_pat[(w.seq*MAX_SMP + w.smp)*MAX_PFR + w.fidx] = int'(w.lval);
         OP_SLEN:   p_slen[w.seq*MAX_SMP + w.smp] =
                       (int'(w.lcnt) > MAX_PFR) ? MAX_PFR : int'(w.lcnt);
         OP_SEQCFG: begin
            p_thr[w.seq]  = int'(w.lval);
            p_nsmp[w.seq] = (int'(w.lcnt) > MAX_SMP) ? MAX_SMP : int'(w.lcnt);
         end
         OP_ALLOW:  p_allow[w.seq] = int'(w.lcnt);
         OP_CLEAR: begin
            p_frames = 0;
            p_rows   = 0;
         end
         default: ;
      endcase
      return v;
   endfunction

   // ---------------- driver ----------------
   word_type on_bus;
   int       burst_left = 4;
   int       gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         // retire the accepted word, then offer the next one unless pausing
         if (req_valid && req_ready) expected_verdicts.push_back(predict_verdict(on_bus));
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            on_bus           = pending_words.pop_front();
            req_valid        <= 1'b1;
            req_opcode       <= on_bus.op;
            req_freq_count   <= on_bus.fcnt;
            req_freq_0       <= on_bus.f[0];
            req_freq_1       <= on_bus.f[1];
            req_freq_2       <= on_bus.f[2];
            req_freq_3       <= on_bus.f[3];
            req_seq_index    <= on_bus.seq;
            req_sample_index <= on_bus.smp;
            req_frame_index  <= on_bus.fidx;
            req_load_value   <= on_bus.lval;
            req_load_count   <= on_bus.lcnt;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = int'($urandom_range(1, 30));
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 12));
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- result monitor ----------------
   int stall_tick = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   always @(posedge clock) begin
      verdict_type exp_v;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               exp_v = expected_verdicts.pop_front();
               if (rsp_matched !== exp_v.matched)
                  report_mismatch("matched", int'(rsp_matched), int'(exp_v.matched));
               if (rsp_final_deviation !== exp_v.dev)
                  report_mismatch("final_deviation", int'(rsp_final_deviation),
                                  int'(exp_v.dev));
            end
         end
         // stall pattern cycles through four characters as stall_tick advances
         stall_tick++;
         case ((stall_tick / 3000) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ((stall_tick % 7) < 3);
            default: rsp_ready <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   // ---------------- stimulus ----------------
   // track what has been loaded so no frame reads an unwritten table entry
   bit seq_done [MAX_SEQ];
   bit allow_done [MAX_SEQ];
   bit len_done [MAX_SEQ*MAX_SMP];
   bit pat_done [MAX_SEQ*MAX_SMP*MAX_PFR];
   int shadow_nsmp [MAX_SEQ];
   int shadow_len [MAX_SEQ*MAX_SMP];
   int words_sent = 0;

   function automatic word_type random_word(logic [OP_W-1:0] op);
      word_type w;
      w.op   = op;
      w.fcnt = CNT_W'($urandom_range(0, 7));
      for (int j = 0; j < FREQS; j++) w.f[j] = FREQ_W'($urandom_range(0, 65535));
      w.seq  = SEQ_W'($urandom_range(0, 7));
      w.smp  = SMP_W'($urandom_range(0, 3));
      w.fidx = PFR_W'($urandom_range(0, 31));
      w.lval = FREQ_W'($urandom_range(0, 65535));
      w.lcnt = DEV_W'($urandom_range(0, 255));
      return w;
   endfunction

   function automatic int pick_tone();
      return 1000 + 500 * int'($urandom_range(0, 3));
   endfunction

   task automatic add_word(word_type w);
      case (w.op)
         OP_PFREQ: pat_done[(w.seq*MAX_SMP + w.smp)*MAX_PFR + w.fidx] = 1'b1;
         OP_SLEN: begin
            len_done[w.seq*MAX_SMP + w.smp]   = 1'b1;
            shadow_len[w.seq*MAX_SMP + w.smp] =
               (int'(w.lcnt) > MAX_PFR) ? MAX_PFR : int'(w.lcnt);
         end
         OP_SEQCFG: begin
            seq_done[w.seq]    = 1'b1;
            shadow_nsmp[w.seq] = (int'(w.lcnt) > MAX_SMP) ? MAX_SMP : int'(w.lcnt);
         end
         OP_ALLOW: allow_done[w.seq] = 1'b1;
         default: ;
      endcase
      pending_words.push_back(w);
      words_sent++;
   endtask

   // load words shaped to give plausible sounds
   task automatic add_load(logic [OP_W-1:0] op, int seq, int smp, int fidx);
      word_type w;
      w      = random_word(op);
      w.seq  = SEQ_W'(seq);
      w.smp  = SMP_W'(smp);
      w.fidx = PFR_W'(fidx);
      case (op)
         OP_PFREQ:  w.lval = ($urandom_range(0, 5) == 0) ? '0 : FREQ_W'(pick_tone());
         OP_SLEN:   w.lcnt = ($urandom_range(0, 30) == 0) ? DEV_W'($urandom_range(33, 255))
                                                          : DEV_W'($urandom_range(0, 4));
         OP_SEQCFG: begin
            w.lval = ($urandom_range(0, 9) == 0) ? FREQ_W'($urandom_range(0, 65535))
                                                 : FREQ_W'($urandom_range(10, 120));
            w.lcnt = ($urandom_range(0, 9) == 0) ? DEV_W'($urandom_range(0, 255))
                                                 : DEV_W'($urandom_range(1, 4));
         end
         OP_ALLOW:  w.lcnt = ($urandom_range(0, 9) == 0) ? DEV_W'($urandom_range(0, 255))
                                                         : DEV_W'($urandom_range(0, 2));
         default: ;
      endcase
      add_word(w);
   endtask

   // fill every table entry that a frame can read under n sequences
   task automatic fill_gaps(int n);
      for (int q = 0; q < n; q++) begin
         if (!seq_done[q]) add_load(OP_SEQCFG, q, 0, 0);
         if (!allow_done[q]) add_load(OP_ALLOW, q, 0, 0);
         for (int s = 0; s < shadow_nsmp[q]; s++) begin
            if (!len_done[q*MAX_SMP + s]) add_load(OP_SLEN, q, s, 0);
            for (int i = 0; i < shadow_len[q*MAX_SMP + s]; i++)
               if (!pat_done[(q*MAX_SMP + s)*MAX_PFR + i]) add_load(OP_PFREQ, q, s, i);
         end
      end
   endtask

   task automatic add_frame(int n);
      word_type w;
      fill_gaps(n);
      w = random_word(OP_FRAME);
      if ($urandom_range(0, 9) == 0) w.fcnt = '0;
      else if ($urandom_range(0, 9) != 0) w.fcnt = CNT_W'($urandom_range(1, 4));
      if ($urandom_range(0, 7) != 0)
         for (int j = 0; j < FREQS; j++)
            w.f[j] = FREQ_W'(pick_tone() + int'($urandom_range(0, 160)) - 80);
      add_word(w);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_verdicts.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      case (idx)
         CSR_MAX_DEV:   p_max_dev   = int'(val);
         CSR_ALL_FREQ:  p_all_freq  = int'(val[0]);
         CSR_SEQ_COUNT: p_seq_count = int'(val[3:0]);
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      word_type w;
      int    n, r;
      int    dev_set [6]  = '{2, 0, 254, 255, 5, 12};
      int    all_set [6]  = '{0, 1, 1, 0, 0, 1};
      int    cnt_set [6]  = '{1, 8, 3, 0, 15, 4};

      // hold every input at a known value
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_CLEAR;
      req_freq_count   = '0;
      req_freq_0       = '0;
      req_freq_1       = '0;
      req_freq_2       = '0;
      req_freq_3       = '0;
      req_seq_index    = '0;
      req_sample_index = '0;
      req_frame_index  = '0;
      req_load_value   = '0;
      req_load_count   = '0;
      rsp_ready        = 1'b0;
      csr_write        = 1'b0;
      csr_index        = CSR_MAX_DEV;
      csr_data         = '0;
      p_max_dev   = 2;
      p_all_freq  = 0;
      p_seq_count = 1;
      p_frames    = 0;
      p_rows      = 0;
      for (int k = 0; k < MAX_SEQ; k++) begin
         p_nsmp[k] = 0; p_thr[k] = 0; p_allow[k] = 0; shadow_nsmp[k] = 0;
      end
      for (int k = 0; k < MAX_SEQ*MAX_SMP; k++) begin
         p_slen[k] = 0; shadow_len[k] = 0;
      end
      foreach (p_pat[k]) p_pat[k] = 0;
      foreach (p_hist[k]) p_hist[k] = 0;
      foreach (p_fsize[k]) p_fsize[k] = 0;
      foreach (p_ffreq[k]) p_ffreq[k] = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            wait_drained();
            write_csr(CSR_MAX_DEV, CSR_DAT_W'(dev_set[ph]));
            write_csr(CSR_ALL_FREQ, CSR_DAT_W'(all_set[ph]));
            write_csr(CSR_SEQ_COUNT, CSR_DAT_W'(cnt_set[ph]));
         end
         n = live_sequences();
         // start each setting from an empty window and history
         add_word(random_word(OP_CLEAR));

         if (ph == 0) begin
            // directed: clamped loads, spare opcodes, field extremes, silence
            add_load(OP_SEQCFG, 0, 0, 0);
            w = random_word(OP_SLEN);    w.seq = 3'd7; w.smp = 2'd3; w.lcnt = 8'hFF;
            add_word(w);
            w = random_word(OP_SEQCFG);  w.seq = 3'd7; w.lval = 16'hFFFF; w.lcnt = 8'hFF;
            add_word(w);
            w = random_word(OP_ALLOW);   w.seq = 3'd7; w.lcnt = 8'hFF; add_word(w);
            w = random_word(OP_PFREQ);   w.seq = 3'd7; w.smp = 2'd3; w.fidx = 5'd31;
            w.lval = 16'hFFFF; add_word(w);
            add_word(random_word(3'd6));
            add_word(random_word(3'd7));
            fill_gaps(n);
            w = random_word(OP_FRAME); w.fcnt = '0; add_word(w);
            w = random_word(OP_FRAME); w.fcnt = 3'd7;
            for (int j = 0; j < FREQS; j++) w.f[j] = 16'hFFFF;
            add_word(w);
            w = random_word(OP_FRAME); w.fcnt = 3'd4;
            for (int j = 0; j < FREQS; j++) w.f[j] = 16'h0000;
            add_word(w);
            add_word(random_word(OP_CLEAR));
            add_frame(n);
         end

         // random: mostly frames of the programmed sound, some reprogramming and noise
         for (int k = 0; k < 60; k++) begin
            r = int'($urandom_range(0, 99));
            if (r < 78) add_frame(n);
            else if (r < 94) add_load(OP_W'($urandom_range(OP_PFREQ, OP_ALLOW)),
                                      int'($urandom_range(0, 7)),
                                      int'($urandom_range(0, 3)),
                                      int'($urandom_range(0, 31)));
            else if (r < 97) add_word(random_word(OP_CLEAR));
            else add_word(random_word(OP_W'($urandom_range(6, 7))));
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #200000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
design/tsm_pkg.sv
design/tsm_datapath.sv
design/tsm_ctrl.sv
design/tone_sequence_matcher_unit.sv
tb/tb_tone_sequence_matcher_unit.sv
